[hw/rtl/rln_pkg.sv]
// Shared types, constants and helpers of the residual layer-norm block.
package rln_pkg;

	localparam int MAX_ROW = 64;
	localparam int IDX_W = $clog2(MAX_ROW);
	localparam int CNT_W = $clog2(MAX_ROW + 1);
	localparam int ENTRY_W = 64;
	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_FIRST_SCALE  = 2'd0;
	localparam logic [1:0] REG_SECOND_SCALE = 2'd1;
	localparam logic [1:0] REG_OUTPUT_SCALE = 2'd2;
	localparam logic [1:0] REG_EPSILON      = 2'd3;

	typedef struct packed {
		logic signed [7:0]  first_operand;
		logic signed [7:0]  second_operand;
		logic signed [15:0] gain;
		logic signed [15:0] offset;
		logic               row_end;
	} item_t;

	typedef struct packed {
		logic signed [7:0] quantized;
		logic              row_done;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_ACC, ST_MEAN, ST_MEAN_W, ST_MSQ, ST_MSQ_W, ST_VAR,
		ST_SQRT, ST_RS, ST_RS_W, ST_E_RD, ST_E_Z, ST_E_G, ST_E_Q, ST_E_PUSH
	} state_t;

	// p / 2^sh rounded to nearest, ties to even
	function automatic logic [63:0] round_shift(input logic [63:0] p, input int unsigned sh);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mask;
		mask = (64'd1 << sh) - 64'd1;
		half = 64'd1 << (sh - 1);
		q = p >> sh;
		rem = p & mask;
		if (rem > half || (rem == half && q[0])) begin
			q = q + 64'd1;
		end
		return q;
	endfunction

endpackage

[hw/rtl/residual_layernorm_int8.sv]
// Top level: residual add, row statistics and layer normalization to int8.
//
// Items arrive on the item channel (item_valid/item_stall, payload item).
// Each item's residual sum s is registered on acceptance, then written to
// the row buffer RAM as its square is registered and the running sum
// advances; then the sum of squares and the count advance. An item with
// row_end set, or the one that fills the 64 entry buffer, starts the row
// statistics: two passes of the shared divider (mean, mean of squares), a
// 32-step square root and, unless the root is zero, a third divider pass
// for the reciprocal. Results then leave on the result channel
// (result_valid/result_stall, payload result), one per buffered element;
// each passes the RAM read, three multiply stages and the push before the
// next is read. row_done marks the last one. item_stall is high after each
// acceptance until the item is accumulated, and after a row's last item
// until that row's last result sits in the output register; a stalled
// receiver holds the output register and the emission waits on it. Reset
// clears the accumulators, count, state and output valid; the RAM is not
// cleared and needs no clearing pass. The user writes registers through the
// APB port only while the block is idle; the block does not enforce this.
module residual_layernorm_int8
	import rln_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	state_t state_q, state_d;

	logic [23:0] first_scale_q, second_scale_q, output_scale_q;
	logic [15:0] epsilon_q;

	logic signed [39:0] rsum_q;
	logic [63:0]        sumsq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   k_q;
	logic               result_valid_q;
	result_t            result_q;

	logic signed [31:0] s_q;
	logic signed [15:0] gain_q, offset_q;
	logic               last_q;
	logic [63:0]        sq_q;
	logic signed [31:0] mean_q;
	logic [63:0]        meansq_q, msq_q;
	logic [63:0]        v_q, res_q, bit_q;
	logic [31:0]        rs_q;

	logic [63:0]        zp_s1;
	logic               zneg_s1;
	logic signed [15:0] gain_s1, offset_s1;
	logic [63:0]        gp_s2;
	logic               gneg_s2;
	logic signed [15:0] offset_s2;
	logic [59:0]        qp_s3;
	logic               qneg_s3, qsat_s3;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               accept;
	logic               out_free;
	logic               ram_we, ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               cfg_we;

	assign accept = item_valid && !item_stall;
	assign item_stall = state_q != ST_IDLE;
	assign out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_FIRST_SCALE:  prdata = {8'd0, first_scale_q};
			REG_SECOND_SCALE: prdata = {8'd0, second_scale_q};
			REG_OUTPUT_SCALE: prdata = {8'd0, output_scale_q};
			REG_EPSILON:      prdata = {16'd0, epsilon_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_scale_q  <= 24'd65536;
			second_scale_q <= 24'd65536;
			output_scale_q <= 24'd65536;
			epsilon_q      <= 16'd1;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_FIRST_SCALE:  first_scale_q  <= pwdata[23:0];
				REG_SECOND_SCALE: second_scale_q <= pwdata[23:0];
				REG_OUTPUT_SCALE: output_scale_q <= pwdata[23:0];
				REG_EPSILON:      epsilon_q      <= pwdata[15:0];
				default:          ;
			endcase
		end
	end

	// residual sum, saturated to 32 bits
	logic signed [33:0] s_wide;
	logic signed [31:0] s_sat;
	assign s_wide = 34'($signed({1'b0, first_scale_q}) * item.first_operand)
		+ 34'($signed({1'b0, second_scale_q}) * item.second_operand);
	always_comb begin
		if (s_wide > 34'sh7FFFFFFF) begin
			s_sat = 32'sh7FFFFFFF;
		end else if (s_wide < -34'sh80000000) begin
			s_sat = 32'sh80000000;
		end else begin
			s_sat = s_wide[31:0];
		end
	end

	logic [31:0] s_mag;
	assign s_mag = s_q[31] ? 32'(-s_q) : s_q;

	logic [64:0] sumsq_add;
	assign sumsq_add = {1'b0, sumsq_q} + {1'b0, sq_q};

	logic [39:0] rsum_mag;
	assign rsum_mag = rsum_q[39] ? 40'(-rsum_q) : rsum_q;

	logic [31:0] mean_mag;
	assign mean_mag = mean_q[31] ? 32'(-mean_q) : mean_q;

	logic [63:0] var_base;
	logic [64:0] var_add;
	logic [63:0] var_sum;
	assign var_base = (meansq_q >= msq_q) ? meansq_q - msq_q : 64'd0;
	assign var_add = {1'b0, var_base} + {33'd0, epsilon_q, 16'd0};
	assign var_sum = var_add[64] ? '1 : var_add[63:0];

	logic [63:0] sq_try;
	assign sq_try = res_q + bit_q;

	logic last_out;
	assign last_out = {1'b0, k_q} == cnt_q - CNT_W'(1);

	always_comb begin
		state_d = state_q;
		div_req = '0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_SQ;
			ST_SQ: begin
				ram_we = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (last_q || cnt_q == CNT_W'(MAX_ROW - 1)) state_d = ST_MEAN;
				else state_d = ST_IDLE;
			end
			ST_MEAN: begin
				div_req.start = 1'b1;
				div_req.dividend = {24'd0, rsum_mag};
				div_req.divisor = {{(64 - CNT_W){1'b0}}, cnt_q};
				state_d = ST_MEAN_W;
			end
			ST_MEAN_W: if (div_rsp.done) state_d = ST_MSQ;
			ST_MSQ: begin
				div_req.start = 1'b1;
				div_req.dividend = sumsq_q;
				div_req.divisor = {{(64 - CNT_W){1'b0}}, cnt_q};
				state_d = ST_MSQ_W;
			end
			ST_MSQ_W: if (div_rsp.done) state_d = ST_VAR;
			ST_VAR: state_d = ST_SQRT;
			ST_SQRT: if (bit_q == 64'd0) state_d = ST_RS;
			ST_RS: begin
				if (res_q == 64'd0) begin
					state_d = ST_E_RD;
				end else begin
					div_req.start = 1'b1;
					div_req.dividend = 64'h1_0000_0000;
					div_req.divisor = res_q;
					state_d = ST_RS_W;
				end
			end
			ST_RS_W: if (div_rsp.done) state_d = ST_E_RD;
			ST_E_RD: begin
				ram_re = 1'b1;
				state_d = ST_E_Z;
			end
			ST_E_Z: state_d = ST_E_G;
			ST_E_G: state_d = ST_E_Q;
			ST_E_Q: state_d = ST_E_PUSH;
			ST_E_PUSH: begin
				if (out_free) state_d = last_out ? ST_IDLE : ST_E_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// final rounding and int8 clamp
	logic [63:0] q_mag;
	logic signed [7:0] q_val;
	assign q_mag = round_shift({4'd0, qp_s3}, 28);
	always_comb begin
		if (qneg_s3) begin
			q_val = (qsat_s3 || q_mag >= 64'd128) ? -8'sd128 : 8'(-q_mag[7:0]);
		end else begin
			q_val = (qsat_s3 || q_mag >= 64'd127) ? 8'sd127 : q_mag[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsum_q <= '0;
			sumsq_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_E_PUSH && out_free) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
			case (state_q)
				ST_SQ: rsum_q <= rsum_q + 40'(s_q);
				ST_ACC: begin
					sumsq_q <= sumsq_add[64] ? '1 : sumsq_add[63:0];
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_E_PUSH: begin
					if (out_free) begin
						k_q <= last_out ? '0 : k_q + IDX_W'(1);
						if (last_out) begin
							rsum_q <= '0;
							sumsq_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	logic signed [32:0] d_val;
	logic [32:0]        d_abs;
	logic [63:0]        z_rnd;
	logic [48:0]        z_mag;
	logic [15:0]        gain_mag;
	logic [63:0]        g_mag;
	logic signed [49:0] g_val;
	logic signed [49:0] o_val;
	logic [49:0]        o_mag;

	assign d_val = 33'($signed(ram_rdata[63:32])) - 33'(mean_q);
	assign d_abs = d_val[32] ? 33'(-d_val) : d_val;
	assign z_rnd = round_shift(zp_s1, 16);
	assign z_mag = z_rnd[48:0];
	assign gain_mag = gain_s1[15] ? 16'(-gain_s1) : gain_s1;
	assign g_mag = round_shift(gp_s2, 16);
	assign g_val = gneg_s2 ? 50'(-$signed({1'b0, g_mag[48:0]})) : $signed({1'b0, g_mag[48:0]});
	assign o_val = g_val + 50'(offset_s2);
	assign o_mag = o_val[49] ? 50'(-o_val) : o_val;

	always_ff @(posedge clk) begin
		if (result_valid_q == 1'b0 || !result_stall || state_q == ST_E_PUSH) begin
			if (state_q == ST_E_PUSH && out_free) begin
				result_q.quantized <= q_val;
				result_q.row_done <= last_out;
			end
		end
		case (state_q)
			ST_IDLE: begin
				s_q <= s_sat;
				gain_q <= item.gain;
				offset_q <= item.offset;
				last_q <= item.row_end;
			end
			ST_SQ: sq_q <= 64'(s_mag) * 64'(s_mag);
			ST_MEAN_W: begin
				if (div_rsp.done) begin
					mean_q <= rsum_q[39] ? 32'(-div_rsp.quotient[31:0])
						: div_rsp.quotient[31:0];
				end
			end
			ST_MSQ: msq_q <= 64'(mean_mag) * 64'(mean_mag);
			ST_MSQ_W: if (div_rsp.done) meansq_q <= div_rsp.quotient;
			ST_VAR: begin
				v_q <= var_sum;
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (bit_q != 64'd0) begin
					if (v_q >= sq_try) begin
						v_q <= v_q - sq_try;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			ST_RS: if (res_q == 64'd0) rs_q <= '1;
			ST_RS_W: begin
				if (div_rsp.done) begin
					rs_q <= (div_rsp.quotient > 64'hFFFF_FFFF) ? '1 : div_rsp.quotient[31:0];
				end
			end
			ST_E_Z: begin
				zp_s1 <= 64'(d_abs[31:0]) * 64'(rs_q);
				zneg_s1 <= d_val[32];
				gain_s1 <= $signed(ram_rdata[31:16]);
				offset_s1 <= $signed(ram_rdata[15:0]);
			end
			ST_E_G: begin
				gp_s2 <= 64'(z_mag) * 64'(gain_mag);
				gneg_s2 <= zneg_s1 ^ gain_s1[15];
				offset_s2 <= offset_s1;
			end
			ST_E_Q: begin
				qp_s3 <= (output_scale_q == 24'd0) ? 60'd0
					: 60'(o_mag[35:0]) * 60'(output_scale_q);
				qneg_s3 <= o_val[49];
				qsat_s3 <= (output_scale_q != 24'd0) && (o_mag[49:36] != 14'd0);
			end
			default: ;
		endcase
	end

	rln_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ROW)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({s_q, gain_q, offset_q}),
		.re    (ram_re),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	rln_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[hw/rtl/rln_ram.sv]
// Generic single-port-write, registered-read RAM.
module rln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/rln_div.sv]
// Iterative 64 by 64 bit unsigned restoring divider, one quotient bit a cycle.
module rln_div
	import rln_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [64:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[63:0], quo_q[63]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hw/rtl/rln_checker.sv]
// Port-level checks of the residual layer-norm block, bound to the top level.
module rln_checker
	import rln_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// each accepted request raises item_stall in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken back to back");

	// a mid-row result implies the row is still draining
	a_mid_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.row_done |-> item_stall)
		else $error("input open while row still draining");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

endmodule

bind residual_layernorm_int8 rln_checker u_rln_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
